// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the sequencer RTL.
// Include once per file that asserts; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, also checked during reset
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/i2cws_pkg.sv -----
// Package for the I2C write-then-read sequencer: phase, action and status codes,
// field widths and address masks. No dependencies.
package i2cws_pkg;

    localparam int CNT_W  = 16;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] ADDR_WRITE_MASK = 8'hFE;
    localparam logic [BYTE_W-1:0] ADDR_READ_BIT   = 8'h01;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WADDR = 2'd1,
        PH_WDATA = 2'd2,
        PH_READ  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_ADDR  = 3'd1,
        ACT_DATA  = 3'd2,
        ACT_RECV  = 3'd3,
        ACT_NSTOP = 3'd4,
        ACT_STOP  = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_BUSY   = 3'd1,
        ST_BUSERR = 3'd2,
        ST_NACK   = 3'd3,
        ST_NORIF  = 3'd4
    } t_status;

    typedef enum logic {
        OP_START = 1'b0,
        OP_EVENT = 1'b1
    } t_op;

endpackage

// ----- hdl/i2cws_in_if.sv -----
// Input channel of the sequencer: start requests and bus engine events.
// Depends on i2cws_pkg for field widths.
interface i2cws_in_if import i2cws_pkg::*;;
    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] slave_address;
    logic [CNT_W-1:0]  write_count;
    logic [CNT_W-1:0]  read_count;
    logic              write_flag;
    logic              read_flag;
    logic              bus_fault;
    logic              nack_seen;
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] tx_byte;

    modport source (
        output valid, op, slave_address, write_count, read_count,
               write_flag, read_flag, bus_fault, nack_seen, rx_byte, tx_byte,
        input  ready
    );
    modport sink (
        input  valid, op, slave_address, write_count, read_count,
               write_flag, read_flag, bus_fault, nack_seen, rx_byte, tx_byte,
        output ready
    );
endinterface

// ----- hdl/i2cws_out_if.sv -----
// Result channel of the sequencer: bus commands, read data and status.
// Depends on i2cws_pkg for field widths.
interface i2cws_out_if import i2cws_pkg::*;;
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [BYTE_W-1:0] out_byte;
    logic              read_valid;
    logic [BYTE_W-1:0] read_byte;
    logic              done_res;
    logic [2:0]        status;

    modport source (
        output valid, action, out_byte, read_valid, read_byte, done_res, status,
        input  ready
    );
    modport sink (
        input  valid, action, out_byte, read_valid, read_byte, done_res, status,
        output ready
    );
endinterface

// ----- hdl/i2c_write_read_sequencer_unit.sv -----
// I2C write-then-read sequencer: one transaction in gives at most one result.
// A result is registered and valid in the cycle after its input transaction is accepted.
// Throughput: one input transaction per cycle; the result register frees as it drains.
// Input is stalled only while the result register holds an untaken result.
// Synchronous active-low reset returns the phase to idle and clears the counters.
// Depends on i2cws_pkg, i2cws_in_if, i2cws_out_if and assert_macros.svh.
`include "assert_macros.svh"

module i2c_write_read_sequencer_unit import i2cws_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    i2cws_in_if.sink    i_in,
    i2cws_out_if.source o_out
);

    t_phase            r_phase,        n_phase;
    logic [CNT_W-1:0]  r_writes_left,  n_writes_left;
    logic [CNT_W-1:0]  r_reads_left,   n_reads_left;
    logic [BYTE_W-1:0] r_held_address, n_held_address;

    logic              r_out_valid;
    t_action           r_action;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_read_valid;
    logic [BYTE_W-1:0] r_read_byte;
    logic              r_done;
    t_status           r_status;

    logic              in_acc;
    logic              res_emit;
    t_action           res_action;
    logic [BYTE_W-1:0] res_out_byte;
    logic              res_read_valid;
    logic              res_done;
    t_status           res_status;

    logic              wl_nz;
    logic              rl_nz;
    logic [CNT_W-1:0]  wl_dec;
    logic [CNT_W-1:0]  rl_dec;

    // Accept while the result register is empty or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    assign wl_nz  = (r_writes_left != '0);
    assign rl_nz  = (r_reads_left != '0);
    assign wl_dec = wl_nz ? r_writes_left - CNT_W'(1) : r_writes_left;
    assign rl_dec = rl_nz ? r_reads_left - CNT_W'(1) : r_reads_left;

    // Next phase and counters
    always_comb begin
        n_phase        = r_phase;
        n_writes_left  = r_writes_left;
        n_reads_left   = r_reads_left;
        n_held_address = r_held_address;
        if (i_in.op == OP_START) begin
            if (r_phase == PH_IDLE) begin
                n_held_address = i_in.slave_address;
                n_writes_left  = i_in.write_count;
                n_reads_left   = i_in.read_count;
                if (i_in.write_count != '0) begin
                    n_phase = PH_WADDR;
                end else if (i_in.read_count != '0) begin
                    n_phase = PH_READ;
                end
            end
        end else begin
            case (r_phase)
                PH_WADDR: begin
                    if (i_in.write_flag) begin
                        if (i_in.bus_fault || i_in.nack_seen) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_writes_left = wl_dec;
                            n_phase       = PH_WDATA;
                        end
                    end
                end
                PH_WDATA: begin
                    if (i_in.write_flag) begin
                        if (i_in.bus_fault || i_in.nack_seen) begin
                            n_phase = PH_IDLE;
                        end else if (wl_nz) begin
                            n_writes_left = wl_dec;
                        end else if (rl_nz) begin
                            n_phase = PH_READ;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_READ: begin
                    if (i_in.write_flag || i_in.read_flag) begin
                        if (i_in.bus_fault || i_in.nack_seen || !i_in.read_flag) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_reads_left = rl_dec;
                            if (rl_dec == '0) begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Result of the current transaction
    always_comb begin
        res_emit       = 1'b0;
        res_action     = ACT_NONE;
        res_out_byte   = '0;
        res_read_valid = 1'b0;
        res_done       = 1'b0;
        res_status     = ST_OK;
        if (i_in.op == OP_START) begin
            res_emit = 1'b1;
            if (r_phase != PH_IDLE) begin
                res_done   = 1'b1;
                res_status = ST_BUSY;
            end else if (i_in.write_count != '0) begin
                res_action   = ACT_ADDR;
                res_out_byte = i_in.slave_address & ADDR_WRITE_MASK;
            end else if (i_in.read_count != '0) begin
                res_action   = ACT_ADDR;
                res_out_byte = i_in.slave_address | ADDR_READ_BIT;
            end else begin
                res_action = ACT_NSTOP;
                res_done   = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_WADDR, PH_WDATA: begin
                    if (i_in.write_flag) begin
                        res_emit = 1'b1;
                        if (i_in.bus_fault) begin
                            res_action = ACT_STOP;
                            res_done   = 1'b1;
                            res_status = ST_BUSERR;
                        end else if (i_in.nack_seen) begin
                            res_action = ACT_STOP;
                            res_done   = 1'b1;
                            // NACK on the final write byte with nothing to read is success
                            res_status = (r_phase == PH_WADDR || wl_nz || rl_nz)
                                         ? ST_NACK : ST_OK;
                        end else if (r_phase == PH_WADDR || wl_nz) begin
                            res_action   = ACT_DATA;
                            res_out_byte = i_in.tx_byte;
                        end else if (rl_nz) begin
                            res_action   = ACT_ADDR;
                            res_out_byte = r_held_address | ADDR_READ_BIT;
                        end else begin
                            res_action = ACT_NSTOP;
                            res_done   = 1'b1;
                        end
                    end
                end
                PH_READ: begin
                    if (i_in.write_flag || i_in.read_flag) begin
                        res_emit = 1'b1;
                        if (i_in.bus_fault) begin
                            res_action = ACT_STOP;
                            res_done   = 1'b1;
                            res_status = ST_BUSERR;
                        end else if (i_in.nack_seen) begin
                            res_action = ACT_STOP;
                            res_done   = 1'b1;
                            res_status = ST_NACK;
                        end else if (!i_in.read_flag) begin
                            res_action = ACT_STOP;
                            res_done   = 1'b1;
                            res_status = ST_NORIF;
                        end else if (rl_dec != '0) begin
                            res_action     = ACT_RECV;
                            res_read_valid = 1'b1;
                        end else begin
                            res_action     = ACT_NSTOP;
                            res_read_valid = 1'b1;
                            res_done       = 1'b1;
                        end
                    end
                end
                default: begin
                    res_emit = 1'b0;
                end
            endcase
        end
    end

    // Advance sequencer state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_writes_left  <= '0;
            r_reads_left   <= '0;
            r_held_address <= '0;
        end else if (in_acc) begin
            r_phase        <= n_phase;
            r_writes_left  <= n_writes_left;
            r_reads_left   <= n_reads_left;
            r_held_address <= n_held_address;
        end
    end

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= in_acc && res_emit;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (in_acc && res_emit) begin
            r_action     <= res_action;
            r_out_byte   <= res_out_byte;
            r_read_valid <= res_read_valid;
            r_read_byte  <= res_read_valid ? i_in.rx_byte : '0;
            r_done       <= res_done;
            r_status     <= res_status;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.action     = r_action;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.read_valid = r_read_valid;
    assign o_out.read_byte  = r_read_byte;
    assign o_out.done_res   = r_done;
    assign o_out.status     = r_status;

    // A finished transaction leaves the sequencer idle
    `ASSERT_CLK(a_done_goes_idle, i_clk, i_rst_n, in_acc && res_emit && res_done && res_status != ST_BUSY |=> r_phase == PH_IDLE, "finished transaction did not return to idle")
    // Received data only travels with a receive or final NACK command
    `ASSERT_CLK(a_read_action, i_clk, i_rst_n, r_out_valid && r_read_valid |-> (r_action == ACT_RECV || r_action == ACT_NSTOP), "read data without receive action")
    // An unfinished result carries a clean status
    `ASSERT_CLK(a_status_clean, i_clk, i_rst_n, r_out_valid && !r_done |-> r_status == ST_OK, "status set on unfinished result")
    // A data byte sent from the data phase consumes one write count
    `ASSERT_CLK(a_write_count, i_clk, i_rst_n, in_acc && i_in.op == OP_EVENT && r_phase == PH_WDATA && res_action == ACT_DATA |=> r_writes_left == $past(r_writes_left) - CNT_W'(1), "write count did not step")

endmodule
